// ----- design/wp_plan_pkg.sv -----
// Package for the waypoint heading and speed planner: widths, register
// indexes, reset values, the CORDIC arctangent table and shared structs.
// No dependencies; every other design file refers to it by scoped names.
package wp_plan_pkg;

	// Coordinate width and number of CORDIC rotations
	localparam int COORD_WIDTH  = 16;
	localparam int CORDIC_STEPS = 16;

	// Position difference, absolute distance and CORDIC widths
	localparam int DIFF_W      = COORD_WIDTH + 1;
	localparam int ABS_W       = (DIFF_W > 17) ? DIFF_W : 17;
	localparam int CORDIC_FRAC = 16;
	localparam int CX_W        = DIFF_W + CORDIC_FRAC + 3;
	localparam int ACC_W       = 25;
	localparam int STEP_W      = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam int TAB_IDX_W   = 5;

	// Output ranges, heading in 1/128 degree, accumulator in 1/32768 degree
	localparam int HEAD_W       = 16;
	localparam int HEAD_MAX     = 23040;
	localparam int HEAD_QUARTER = 11520;
	localparam int ACC_QUARTER  = 2949120;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int DIST_W     = 16;
	localparam int SPEED_W    = 8;

	localparam logic [CFG_IDX_W-1:0] REG_ARRIVAL_DIST = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NEAR_DIST    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CRUISE_SPEED = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_APPR_SPEED   = 2'd3;

	localparam logic [DIST_W-1:0]  ARRIVAL_DIST_RST = 16'd30;
	localparam logic [DIST_W-1:0]  NEAR_DIST_RST    = 16'd150;
	localparam logic [SPEED_W-1:0] CRUISE_SPEED_RST = 8'd60;
	localparam logic [SPEED_W-1:0] APPR_SPEED_RST   = 8'd20;

	// atan(2^-i) in degrees times 32768, rounded to nearest
	function automatic logic signed [ACC_W-1:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
		logic signed [ACC_W-1:0] val;
		case (idx)
			5'd0:    val = 25'sd1474560;
			5'd1:    val = 25'sd870484;
			5'd2:    val = 25'sd459940;
			5'd3:    val = 25'sd233473;
			5'd4:    val = 25'sd117189;
			5'd5:    val = 25'sd58652;
			5'd6:    val = 25'sd29333;
			5'd7:    val = 25'sd14667;
			5'd8:    val = 25'sd7334;
			5'd9:    val = 25'sd3667;
			5'd10:   val = 25'sd1833;
			5'd11:   val = 25'sd917;
			5'd12:   val = 25'sd458;
			5'd13:   val = 25'sd229;
			5'd14:   val = 25'sd115;
			5'd15:   val = 25'sd57;
			5'd16:   val = 25'sd29;
			5'd17:   val = 25'sd14;
			5'd18:   val = 25'sd7;
			5'd19:   val = 25'sd4;
			5'd20:   val = 25'sd2;
			5'd21:   val = 25'sd1;
			default: val = '0;
		endcase
		return val;
	endfunction

	// Result of the distance comparison unit
	typedef struct packed {
		logic done;
		logic arrived;
		logic far;
	} dist_res_t;

	// Result of the CORDIC heading unit
	typedef struct packed {
		logic                     done;
		logic signed [HEAD_W-1:0] heading;
	} cordic_res_t;

endpackage

// ----- design/wp_plan_if.sv -----
// Valid/ready channel interfaces for planner ticks and planner results.
// Depends on wp_plan_pkg for the coordinate and speed widths.
interface wp_plan_in_if;
	logic                                       valid;
	logic                                       ready;
	logic                                       system_on;
	logic                                       auto_mode;
	logic                                       start_nav;
	logic signed [wp_plan_pkg::COORD_WIDTH-1:0] pos_x;
	logic signed [wp_plan_pkg::COORD_WIDTH-1:0] pos_y;
	logic signed [wp_plan_pkg::COORD_WIDTH-1:0] target_x;
	logic signed [wp_plan_pkg::COORD_WIDTH-1:0] target_y;

	modport source (output valid, system_on, auto_mode, start_nav, pos_x, pos_y,
		target_x, target_y, input ready);
	modport sink (input valid, system_on, auto_mode, start_nav, pos_x, pos_y,
		target_x, target_y, output ready);
endinterface

interface wp_plan_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [wp_plan_pkg::HEAD_W-1:0] heading;
	logic                                  heading_valid;
	logic [wp_plan_pkg::SPEED_W-1:0]       speed_setpoint;
	logic                                  speed_valid;
	logic                                  arrived;
	logic                                  nav_active;

	modport source (output valid, heading, heading_valid, speed_setpoint, speed_valid,
		arrived, nav_active, input ready);
	modport sink (input valid, heading, heading_valid, speed_setpoint, speed_valid,
		arrived, nav_active, output ready);
endinterface

// ----- design/wp_plan_dist.sv -----
// Squared distance comparison using one shared 16 x 16 multiplier.
// Depends on wp_plan_pkg for widths and the result struct.
module wp_plan_dist (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [wp_plan_pkg::DIST_W-1:0]  abs_x,
	input  logic [wp_plan_pkg::DIST_W-1:0]  abs_y,
	input  logic                            big,
	input  logic [wp_plan_pkg::DIST_W-1:0]  arrival_dist,
	input  logic [wp_plan_pkg::DIST_W-1:0]  near_dist,
	output wp_plan_pkg::dist_res_t          res
);

	localparam logic [2:0] STEP_SQ_X   = 3'd0;
	localparam logic [2:0] STEP_SQ_Y   = 3'd1;
	localparam logic [2:0] STEP_SQ_ARR = 3'd2;
	localparam logic [2:0] STEP_SQ_NR  = 3'd3;
	localparam logic [2:0] STEP_LAST   = 3'd4;

	logic [2:0]                        step_q;
	logic                              busy_q;
	logic                              done_q;
	logic                              arrived_q;
	logic                              far_q;
	logic                              big_q;
	logic [wp_plan_pkg::DIST_W-1:0]    ax_q;
	logic [wp_plan_pkg::DIST_W-1:0]    ay_q;
	logic [wp_plan_pkg::DIST_W-1:0]    mul_op;
	logic [2*wp_plan_pkg::DIST_W-1:0]  prod_q;
	logic [2*wp_plan_pkg::DIST_W:0]    d2_q;

	always_comb begin
		case (step_q)
			STEP_SQ_X:   mul_op = ax_q;
			STEP_SQ_Y:   mul_op = ay_q;
			STEP_SQ_ARR: mul_op = arrival_dist;
			STEP_SQ_NR:  mul_op = near_dist;
			default:     mul_op = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= STEP_SQ_X;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= STEP_SQ_X;
		end else if (busy_q) begin
			if (step_q == STEP_LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				step_q <= step_q + 3'd1;
			end
		end
	end

	// Each product is registered and consumed in the next cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			ax_q  <= abs_x;
			ay_q  <= abs_y;
			big_q <= big;
		end else if (busy_q) begin
			prod_q <= mul_op * mul_op;
			case (step_q)
				STEP_SQ_Y:   d2_q <= {1'b0, prod_q};
				STEP_SQ_ARR: d2_q <= d2_q + {1'b0, prod_q};
				STEP_SQ_NR:  arrived_q <= !big_q && (d2_q < {1'b0, prod_q});
				STEP_LAST:   far_q <= big_q || (d2_q > {1'b0, prod_q});
				default:     ;
			endcase
		end
	end

	assign res.done    = done_q;
	assign res.arrived = arrived_q;
	assign res.far     = far_q;

endmodule

// ----- design/wp_plan_cordic.sv -----
// Iterative vectoring CORDIC giving atan2(dy, dx) in 1/128 degree, one rotation a cycle.
// Depends on wp_plan_pkg for widths, the arctangent table and the result struct.
module wp_plan_cordic (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [wp_plan_pkg::DIFF_W-1:0] dx,
	input  logic signed [wp_plan_pkg::DIFF_W-1:0] dy,
	output wp_plan_pkg::cordic_res_t              res
);

	typedef enum logic [3:0] {
		C_IDLE = 4'b0001,
		C_ITER = 4'b0010,
		C_FIN  = 4'b0100,
		C_DONE = 4'b1000
	} cstate_t;

	localparam int CX_W  = wp_plan_pkg::CX_W;
	localparam int ACC_W = wp_plan_pkg::ACC_W;
	localparam int EXT_W = CX_W - wp_plan_pkg::DIFF_W;

	cstate_t                                state_q;
	logic [wp_plan_pkg::STEP_W-1:0]         step_q;
	logic signed [CX_W-1:0]                 x_q;
	logic signed [CX_W-1:0]                 y_q;
	logic signed [ACC_W-1:0]                acc_q;
	logic signed [wp_plan_pkg::HEAD_W-1:0]  heading_q;

	logic signed [CX_W-1:0]                 dx_sc;
	logic signed [CX_W-1:0]                 dy_sc;
	logic signed [CX_W-1:0]                 x_sh;
	logic signed [CX_W-1:0]                 y_sh;
	logic signed [ACC_W-1:0]                ang;
	logic [ACC_W-1:0]                       mag;
	logic [ACC_W-1:0]                       rnd;
	logic [wp_plan_pkg::HEAD_W-1:0]         rnd_clamped;
	logic                                   last_step;

	assign dx_sc = {{EXT_W{dx[wp_plan_pkg::DIFF_W-1]}}, dx} <<< wp_plan_pkg::CORDIC_FRAC;
	assign dy_sc = {{EXT_W{dy[wp_plan_pkg::DIFF_W-1]}}, dy} <<< wp_plan_pkg::CORDIC_FRAC;

	// Arithmetic right shifts round towards minus infinity, as the rotation needs.
	assign x_sh      = x_q >>> step_q;
	assign y_sh      = y_q >>> step_q;
	assign ang       = wp_plan_pkg::atan_entry(wp_plan_pkg::TAB_IDX_W'(step_q));
	assign last_step = (step_q == wp_plan_pkg::STEP_W'(wp_plan_pkg::CORDIC_STEPS - 1));

	// Divide by 256 with rounding half away from zero, then limit to half a turn.
	assign mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
	assign rnd = (mag + ACC_W'(128)) >> 8;
	assign rnd_clamped = (rnd > ACC_W'(wp_plan_pkg::HEAD_MAX)) ?
		wp_plan_pkg::HEAD_W'(wp_plan_pkg::HEAD_MAX) : rnd[wp_plan_pkg::HEAD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			step_q  <= '0;
		end else if (start) begin
			step_q <= '0;
			if (dx == '0 || dy == '0) begin
				state_q <= C_DONE;
			end else begin
				state_q <= C_ITER;
			end
		end else begin
			case (state_q)
				C_ITER: begin
					if (last_step) begin
						state_q <= C_FIN;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				C_FIN:   state_q <= C_DONE;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			if (dy == '0) begin
				heading_q <= dx[wp_plan_pkg::DIFF_W-1] ?
					wp_plan_pkg::HEAD_W'(wp_plan_pkg::HEAD_MAX) : '0;
			end else if (dx == '0) begin
				heading_q <= dy[wp_plan_pkg::DIFF_W-1] ?
					-wp_plan_pkg::HEAD_W'(wp_plan_pkg::HEAD_QUARTER) :
					wp_plan_pkg::HEAD_W'(wp_plan_pkg::HEAD_QUARTER);
			end
			// Targets behind the vehicle are turned by a quarter first.
			if (dx[wp_plan_pkg::DIFF_W-1] && !dy[wp_plan_pkg::DIFF_W-1]) begin
				x_q   <= dy_sc;
				y_q   <= -dx_sc;
				acc_q <= ACC_W'(wp_plan_pkg::ACC_QUARTER);
			end else if (dx[wp_plan_pkg::DIFF_W-1]) begin
				x_q   <= -dy_sc;
				y_q   <= dx_sc;
				acc_q <= -ACC_W'(wp_plan_pkg::ACC_QUARTER);
			end else begin
				x_q   <= dx_sc;
				y_q   <= dy_sc;
				acc_q <= '0;
			end
		end else if (state_q == C_ITER) begin
			if (y_q > 0) begin
				x_q   <= x_q + y_sh;
				y_q   <= y_q - x_sh;
				acc_q <= acc_q + ang;
			end else begin
				x_q   <= x_q - y_sh;
				y_q   <= y_q + x_sh;
				acc_q <= acc_q - ang;
			end
		end else if (state_q == C_FIN) begin
			heading_q <= acc_q[ACC_W-1] ? -rnd_clamped : rnd_clamped;
		end
	end

	assign res.done    = (state_q == C_DONE);
	assign res.heading = heading_q;

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == C_DONE) |->
		(heading_q <= wp_plan_pkg::HEAD_W'(wp_plan_pkg::HEAD_MAX) &&
		 heading_q >= -wp_plan_pkg::HEAD_W'(wp_plan_pkg::HEAD_MAX)))
		else $error("CORDIC heading outside half a turn");

endmodule

// ----- design/waypoint_heading_speed_planner_unit.sv -----
// Top level of the waypoint heading and speed planner: control sequencer,
// configuration registers, navigation flag and result register.
// Depends on wp_plan_pkg, wp_plan_if, wp_plan_dist and wp_plan_cordic.
//
//   Channel   Direction  Handshake          Carries
//   in_ch     in         valid / ready      one planning tick: flags and positions
//   out_ch    out        valid / ready      one result: heading, speed, flags
//   cfg       in         cfg_we only        register index and data, no read-back
//
// An evaluated tick runs the CORDIC unit, one rotation a cycle (CORDIC_STEPS of them),
// then a rounding step, then the load of the output register, while the distance unit
// runs its multiplier steps alongside. Offsets along an axis skip the rotations, so the
// distance unit alone decides when their result is ready. Ticks that are not evaluated
// go straight to the output register. Input ready returns together with the loaded
// result, so a new tick can only be transferred once the previous result is loaded.
// Reset clears the navigation flag, the sequencer and the configuration registers
// to their defaults. Input ready is high only while the sequencer is idle; a result
// that is not taken stays in the output register and the next tick may still be
// transferred, but its own result waits until the register is free.
module waypoint_heading_speed_planner_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	wp_plan_in_if.sink                          in_ch,
	wp_plan_out_if.source                       out_ch,
	input  logic                                cfg_we,
	input  logic [wp_plan_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [wp_plan_pkg::CFG_DATA_W-1:0]  cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_CALC = 2'b10
	} state_t;

	localparam int DIFF_W  = wp_plan_pkg::DIFF_W;
	localparam int COORD_W = wp_plan_pkg::COORD_WIDTH;
	localparam int ABS_W   = wp_plan_pkg::ABS_W;

	state_t                                 state_q;
	logic                                   nav_q;
	logic                                   eval_q;

	logic [wp_plan_pkg::DIST_W-1:0]         arrival_dist_q;
	logic [wp_plan_pkg::DIST_W-1:0]         near_dist_q;
	logic [wp_plan_pkg::SPEED_W-1:0]        cruise_speed_q;
	logic [wp_plan_pkg::SPEED_W-1:0]        appr_speed_q;

	logic                                   out_valid_q;
	logic signed [wp_plan_pkg::HEAD_W-1:0]  heading_q;
	logic                                   heading_valid_q;
	logic [wp_plan_pkg::SPEED_W-1:0]        speed_q;
	logic                                   speed_valid_q;
	logic                                   arrived_q;
	logic                                   nav_active_q;

	logic                                   accept;
	logic                                   nav_next;
	logic                                   eval_now;
	logic                                   unit_start;
	logic                                   units_done;
	logic                                   finish;
	logic signed [DIFF_W-1:0]               dx;
	logic signed [DIFF_W-1:0]               dy;
	logic [ABS_W-1:0]                       abs_x;
	logic [ABS_W-1:0]                       abs_y;
	logic                                   big;

	wp_plan_pkg::dist_res_t                 dist_res;
	wp_plan_pkg::cordic_res_t               cordic_res;

	// A start request raises the navigation flag before the tick is evaluated.
	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign nav_next    = nav_q || in_ch.start_nav;
	assign eval_now    = in_ch.system_on && nav_next && in_ch.auto_mode;
	assign unit_start  = accept && eval_now;

	// Offsets to the target, one bit wider than the coordinates so that they cannot wrap.
	assign dx = {in_ch.target_x[COORD_W-1], in_ch.target_x} -
		{in_ch.pos_x[COORD_W-1], in_ch.pos_x};
	assign dy = {in_ch.target_y[COORD_W-1], in_ch.target_y} -
		{in_ch.pos_y[COORD_W-1], in_ch.pos_y};
	assign abs_x = dx[DIFF_W-1] ? ABS_W'(-dx) : ABS_W'(dx);
	assign abs_y = dy[DIFF_W-1] ? ABS_W'(-dy) : ABS_W'(dy);

	// An offset beyond sixteen bits is certainly past every threshold.
	assign big = (abs_x > ABS_W'(65535)) || (abs_y > ABS_W'(65535));

	wp_plan_dist u_dist (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (unit_start),
		.abs_x        (abs_x[wp_plan_pkg::DIST_W-1:0]),
		.abs_y        (abs_y[wp_plan_pkg::DIST_W-1:0]),
		.big          (big),
		.arrival_dist (arrival_dist_q),
		.near_dist    (near_dist_q),
		.res          (dist_res)
	);

	wp_plan_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (unit_start),
		.dx     (dx),
		.dy     (dy),
		.res    (cordic_res)
	);

	// The result is written once any units used are done and the output register is free.
	assign units_done = !eval_q || (dist_res.done && cordic_res.done);
	assign finish     = (state_q == ST_CALC) && units_done && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arrival_dist_q <= wp_plan_pkg::ARRIVAL_DIST_RST;
			near_dist_q    <= wp_plan_pkg::NEAR_DIST_RST;
			cruise_speed_q <= wp_plan_pkg::CRUISE_SPEED_RST;
			appr_speed_q   <= wp_plan_pkg::APPR_SPEED_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				wp_plan_pkg::REG_ARRIVAL_DIST: arrival_dist_q <= cfg_data;
				wp_plan_pkg::REG_NEAR_DIST:    near_dist_q    <= cfg_data;
				wp_plan_pkg::REG_CRUISE_SPEED: cruise_speed_q <= cfg_data[wp_plan_pkg::SPEED_W-1:0];
				wp_plan_pkg::REG_APPR_SPEED:   appr_speed_q   <= cfg_data[wp_plan_pkg::SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			nav_q       <= 1'b0;
			eval_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CALC;
						nav_q   <= nav_next;
						eval_q  <= eval_now;
					end
				end
				ST_CALC: begin
					if (finish) begin
						state_q <= ST_IDLE;
						if (eval_q && dist_res.arrived) begin
							nav_q <= 1'b0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload: an unevaluated tick reports zeros and the current flag.
	always_ff @(posedge clk) begin
		if (finish) begin
			heading_q       <= '0;
			heading_valid_q <= 1'b0;
			speed_q         <= '0;
			speed_valid_q   <= eval_q;
			arrived_q       <= 1'b0;
			nav_active_q    <= nav_q;
			if (eval_q && dist_res.arrived) begin
				arrived_q    <= 1'b1;
				nav_active_q <= 1'b0;
			end else if (eval_q) begin
				heading_q       <= cordic_res.heading;
				heading_valid_q <= 1'b1;
				speed_q         <= dist_res.far ? cruise_speed_q : appr_speed_q;
			end
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.heading        = heading_q;
	assign out_ch.heading_valid  = heading_valid_q;
	assign out_ch.speed_setpoint = speed_q;
	assign out_ch.speed_valid    = speed_valid_q;
	assign out_ch.arrived        = arrived_q;
	assign out_ch.nav_active     = nav_active_q;

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ch.ready)
		else $error("Planner ready again straight after taking a tick");

	a_finish_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (out_ch.valid && in_ch.ready))
		else $error("Finished tick did not reach the output register");

	a_arrival_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.arrived) |->
		(!out_ch.nav_active && out_ch.speed_valid && !out_ch.heading_valid))
		else $error("Arrival result with inconsistent flags");

endmodule
